FILE: rtl/core/itp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ITM trace packet decoder package
// Shared constants, the parser phase and executor state types and the
// command passed from the parser to the executor.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int ChannelCountDefault = 10;
   localparam int PendingDepthDefault = 16;
   localparam int MaxTimeBytesDefault = 4;
   localparam int CmdDepth            = 4;

   localparam logic [7:0] HdrOverflow = 8'h70;
   localparam logic [7:0] HdrDelayOne = 8'hD0;
   localparam logic [7:0] HdrDelayTwo = 8'hE0;
   localparam logic [7:0] HdrDelayThr = 8'hF0;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_SRC1 = 3'd1,
      PH_SRC2 = 3'd2,
      PH_SRC3 = 3'd3,
      PH_SRC4 = 3'd4,
      PH_TIME = 3'd5,
      PH_SKIP = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE     = 2'd0,
      BK_FOLD_RD  = 2'd1,
      BK_FOLD_USE = 2'd2,
      BK_EMIT     = 2'd3
   } back_state_type;

   // One command per accepted byte that has any effect on the back end.
   typedef struct packed {
      logic        frame_inc;
      logic        err_inc;
      logic [2:0]  delay_inc;
      logic        src_push;
      logic [4:0]  src_ch;
      logic [31:0] src_val;
      logic        close;
      logic [27:0] close_time;
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/core/itm_trace_packet_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ITM trace packet decoder
// Parser, command queue and executor that decode an ITM trace byte stream.
// ----------------------------------------------------------------------------
// The parser takes each trace byte and queues a command for every byte that
// has an effect on the back end; a byte that closes an entry makes the
// executor read and then write each pending source packet into the held row,
// stopping at the first bad channel, then emit the row one channel result at
// a time (CHANNEL_COUNT results) as the output accepts them. Input stalls
// only when the four-entry command queue fills while the executor is folding
// or emitting.
module itm_trace_packet_decoder_core
   import itp_pkg::*;
#(
   parameter int CHANNEL_COUNT  = ChannelCountDefault,
   parameter int PENDING_DEPTH  = PendingDepthDefault,
   parameter int MAX_TIME_BYTES = MaxTimeBytesDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_trace_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [3:0]      rsp_channel_index,
   output logic [31:0]     rsp_channel_value,
   output logic [27:0]     rsp_entry_time,
   output logic            rsp_last_of_entry,
   output logic [31:0]     rsp_frames_seen,
   output logic [31:0]     rsp_error_frames,
   output logic [31:0]     rsp_delayed_count_one,
   output logic [31:0]     rsp_delayed_count_two,
   output logic [31:0]     rsp_delayed_count_three
);

   cmd_type wr_cmd, rd_cmd;
   logic    wr_valid, q_empty, q_pop, accept;

   assign accept = req_push && !req_full;

   // Byte parser.
   itp_front #(
      .PENDING_DEPTH  (PENDING_DEPTH),
      .MAX_TIME_BYTES (MAX_TIME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .byte_data  (req_trace_byte),
      .cmd        (wr_cmd),
      .cmd_valid  (wr_valid)
   );

   // Command queue between parser and executor.
   itp_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_valid),
      .wr_data (wr_cmd),
      .full    (req_full),
      .rd_en   (q_pop),
      .rd_data (rd_cmd),
      .empty   (q_empty)
   );

   // Command executor and result register.
   itp_back #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_back (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (rd_cmd),
      .cmd_empty               (q_empty),
      .cmd_pop                 (q_pop),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_channel_index       (rsp_channel_index),
      .rsp_channel_value       (rsp_channel_value),
      .rsp_entry_time          (rsp_entry_time),
      .rsp_last_of_entry       (rsp_last_of_entry),
      .rsp_frames_seen         (rsp_frames_seen),
      .rsp_error_frames        (rsp_error_frames),
      .rsp_delayed_count_one   (rsp_delayed_count_one),
      .rsp_delayed_count_two   (rsp_delayed_count_two),
      .rsp_delayed_count_three (rsp_delayed_count_three)
   );

endmodule
`default_nettype wire

FILE: rtl/core/itp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ITM trace packet parser
// Classifies trace bytes, assembles source payloads and timestamps, and
// issues one command per effective byte.
// ----------------------------------------------------------------------------
module itp_front
   import itp_pkg::*;
#(
   parameter int PENDING_DEPTH  = PendingDepthDefault,
   parameter int MAX_TIME_BYTES = MaxTimeBytesDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_valid,
   input  wire logic [7:0] byte_data,
   output cmd_type         cmd,
   output logic            cmd_valid
);

   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam int SatBits = 7 * MAX_TIME_BYTES;
   localparam logic [27:0] TimeSat = 28'((64'd1 << SatBits) - 64'd1);

   phase_type   phase_ff, phase_in;
   logic [1:0]  size_ff, size_in;
   logic [CW-1:0] pcount_ff, pcount_in;
   logic [31:0] val_ff, val_in;
   logic [4:0]  ch_ff, ch_in;
   logic [27:0] tacc_ff, tacc_in;
   logic [2:0]  tcnt_ff, tcnt_in;
   logic        tover_ff, tover_in;
   logic        slot_free;
   logic [6:0]  grp;

   assign slot_free = pcount_ff < CW'(PENDING_DEPTH);
   assign grp = byte_data[6:0];

   // Byte classification and next parser state.
   always_comb begin
      phase_in = phase_ff;
      size_in = size_ff;
      pcount_in = pcount_ff;
      val_in = val_ff;
      ch_in = ch_ff;
      tacc_in = tacc_ff;
      tcnt_in = tcnt_ff;
      tover_in = tover_ff;
      cmd = '0;
      case (phase_ff)
         PH_IDLE: begin
            cmd.frame_inc = 1'b1;
            if (byte_data[1:0] != 2'd0 && !byte_data[2]) begin
               size_in = byte_data[1:0];
               ch_in = byte_data[7:3];
               val_in = '0;
               phase_in = PH_SRC1;
            end else if (byte_data == HdrOverflow) begin
               cmd.err_inc = 1'b1;
            end else if (byte_data[3:0] == 4'd0 && byte_data[6:4] != 3'd0) begin
               cmd.delay_inc[0] = byte_data == HdrDelayOne;
               cmd.delay_inc[1] = byte_data == HdrDelayTwo;
               cmd.delay_inc[2] = byte_data == HdrDelayThr;
               tacc_in = '0;
               tcnt_in = '0;
               tover_in = 1'b0;
               if (byte_data[7]) begin
                  phase_in = PH_TIME;
               end else begin
                  cmd.close = 1'b1;
                  cmd.close_time = 28'(byte_data[6:4]);
                  pcount_in = '0;
               end
            end else if ((byte_data & 8'h0B) == 8'h08) begin
               if (byte_data[7]) begin
                  phase_in = PH_SKIP;
               end
            end else begin
               cmd.err_inc = 1'b1;
            end
         end
         PH_SRC1, PH_SRC2, PH_SRC3, PH_SRC4: begin
            if (phase_ff == PH_SRC1) begin
               val_in[7:0] = byte_data;
            end else if (phase_ff == PH_SRC2) begin
               val_in[15:8] = byte_data;
            end else if (phase_ff == PH_SRC3) begin
               val_in[23:16] = byte_data;
            end else begin
               val_in[31:24] = byte_data;
            end
            if ((phase_ff == PH_SRC1 && size_ff == 2'd1) ||
                (phase_ff == PH_SRC2 && size_ff == 2'd2) || phase_ff == PH_SRC4) begin
               phase_in = PH_IDLE;
               if (slot_free) begin
                  cmd.src_push = 1'b1;
                  cmd.src_ch = ch_ff;
                  cmd.src_val = val_in;
                  pcount_in = pcount_ff + CW'(1);
               end else begin
                  cmd.err_inc = 1'b1;
               end
            end else if (phase_ff == PH_SRC1) begin
               phase_in = PH_SRC2;
            end else if (phase_ff == PH_SRC2) begin
               phase_in = PH_SRC3;
            end else begin
               phase_in = PH_SRC4;
            end
         end
         PH_TIME: begin
            if (tcnt_ff < 3'(MAX_TIME_BYTES)) begin
               for (int k = 0; k < MAX_TIME_BYTES; k++) begin
                  if (tcnt_ff == 3'(k)) begin
                     tacc_in = tacc_ff | (28'(grp) << (7 * k));
                  end
               end
               tcnt_in = tcnt_ff + 3'd1;
            end else if (grp != 7'd0) begin
               tover_in = 1'b1;
            end
            if (!byte_data[7]) begin
               phase_in = PH_IDLE;
               cmd.close = 1'b1;
               cmd.close_time = tover_in ? TimeSat : tacc_in;
               pcount_in = '0;
            end
         end
         PH_SKIP: begin
            if (!byte_data[7]) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      cmd_valid = byte_valid &&
                  (cmd.frame_inc || cmd.err_inc || cmd.src_push || cmd.close);
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         size_ff <= '0;
         pcount_ff <= '0;
         tacc_ff <= '0;
         tcnt_ff <= '0;
         tover_ff <= 1'b0;
      end else if (byte_valid) begin
         phase_ff <= phase_in;
         size_ff <= size_in;
         pcount_ff <= pcount_in;
         tacc_ff <= tacc_in;
         tcnt_ff <= tcnt_in;
         tover_ff <= tover_in;
      end
   end

   // Payload assembly registers.
   always_ff @(posedge clock) begin
      if (byte_valid) begin
         val_ff <= val_in;
         ch_ff <= ch_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/itp_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ITM trace command queue
// Small register queue that decouples the parser from the executor.
// ----------------------------------------------------------------------------
module itp_cmd_queue
   import itp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire cmd_type wr_data,
   output logic         full,
   input  wire logic    rd_en,
   output cmd_type      rd_data,
   output logic         empty
);

   localparam int AW = $clog2(CmdDepth);

   cmd_type       mem_ff [CmdDepth];
   logic [AW-1:0] wptr_ff, rptr_ff;
   logic [AW:0]   count_ff;

   assign full = count_ff == (AW + 1)'(CmdDepth);
   assign empty = count_ff == '0;
   assign rd_data = mem_ff[rptr_ff];

   // Storage write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (wr_en) begin
            wptr_ff <= wptr_ff + AW'(1);
         end
         if (rd_en) begin
            rptr_ff <= rptr_ff + AW'(1);
         end
         count_ff <= count_ff + (AW + 1)'(wr_en) - (AW + 1)'(rd_en);
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/itp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ITM trace command executor
// Keeps the counters and the pending queue, folds it into the held row on
// an entry close, and emits the row one channel per transfer.
// ----------------------------------------------------------------------------
module itp_back
   import itp_pkg::*;
#(
   parameter int CHANNEL_COUNT = ChannelCountDefault,
   parameter int PENDING_DEPTH = PendingDepthDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire logic    cmd_empty,
   output logic         cmd_pop,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output logic [3:0]   rsp_channel_index,
   output logic [31:0]  rsp_channel_value,
   output logic [27:0]  rsp_entry_time,
   output logic         rsp_last_of_entry,
   output logic [31:0]  rsp_frames_seen,
   output logic [31:0]  rsp_error_frames,
   output logic [31:0]  rsp_delayed_count_one,
   output logic [31:0]  rsp_delayed_count_two,
   output logic [31:0]  rsp_delayed_count_three
);

   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam int IW = $clog2(PENDING_DEPTH);
   localparam int EW = $clog2(CHANNEL_COUNT);

   back_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff;
   logic [IW-1:0] idx_ff;
   logic [EW-1:0] emit_ff;
   logic [4:0]    mem_ch [PENDING_DEPTH];
   logic [31:0]   mem_val [PENDING_DEPTH];
   logic [4:0]    rd_ch_ff;
   logic [31:0]   rd_val_ff;
   logic [31:0]   held_ff [CHANNEL_COUNT];
   logic [27:0]   time_ff;
   logic [31:0]   frame_ff, err_ff, dly0_ff, dly1_ff, dly2_ff;
   logic          out_valid_ff;
   logic          wr_en, ch_ok, fold_last, out_load, emit_last;

   assign ch_ok = {1'b0, rd_ch_ff} < 6'(CHANNEL_COUNT);
   assign fold_last = CW'(idx_ff) + CW'(1) == cnt_ff;
   assign emit_last = emit_ff == EW'(CHANNEL_COUNT - 1);
   assign wr_en = cmd_pop && cmd.src_push && cnt_ff < CW'(PENDING_DEPTH);
   assign rsp_empty = !out_valid_ff;

   // Next state and strobes.
   always_comb begin
      state_in = state_ff;
      cmd_pop = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd.close) begin
                  state_in = (cnt_ff == '0) ? BK_EMIT : BK_FOLD_RD;
               end
            end
         end
         BK_FOLD_RD: begin
            state_in = BK_FOLD_USE;
         end
         BK_FOLD_USE: begin
            state_in = (!ch_ok || fold_last) ? BK_EMIT : BK_FOLD_RD;
         end
         BK_EMIT: begin
            out_load = !out_valid_ff || rsp_pop;
            if (out_load && emit_last) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Pending queue storage with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ch[cnt_ff[IW-1:0]] <= cmd.src_ch;
         mem_val[cnt_ff[IW-1:0]] <= cmd.src_val;
      end
      rd_ch_ff <= mem_ch[idx_ff];
      rd_val_ff <= mem_val[idx_ff];
   end

   // Control state, counters and held row.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cnt_ff <= '0;
         idx_ff <= '0;
         emit_ff <= '0;
         frame_ff <= '0;
         err_ff <= '0;
         dly0_ff <= '0;
         dly1_ff <= '0;
         dly2_ff <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (cmd_pop) begin
            frame_ff <= frame_ff + 32'(cmd.frame_inc);
            err_ff <= err_ff + 32'(cmd.err_inc);
            dly0_ff <= dly0_ff + 32'(cmd.delay_inc[0]);
            dly1_ff <= dly1_ff + 32'(cmd.delay_inc[1]);
            dly2_ff <= dly2_ff + 32'(cmd.delay_inc[2]);
            if (wr_en) begin
               cnt_ff <= cnt_ff + CW'(1);
            end
            if (cmd.close) begin
               time_ff <= cmd.close_time;
               idx_ff <= '0;
               emit_ff <= '0;
               if (cnt_ff == '0) begin
                  cnt_ff <= '0;
               end
            end
         end
         if (state_ff == BK_FOLD_USE) begin
            if (!ch_ok) begin
               err_ff <= err_ff + 32'd1;
               cnt_ff <= '0;
            end else begin
               held_ff[rd_ch_ff[EW-1:0]] <= rd_val_ff;
               if (fold_last) begin
                  cnt_ff <= '0;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
               end
            end
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
            emit_ff <= emit_last ? '0 : emit_ff + EW'(1);
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_channel_index <= 4'(emit_ff);
         rsp_channel_value <= held_ff[emit_ff];
         rsp_entry_time <= time_ff;
         rsp_last_of_entry <= emit_last;
         rsp_frames_seen <= frame_ff;
         rsp_error_frames <= err_ff;
         rsp_delayed_count_one <= dly0_ff;
         rsp_delayed_count_two <= dly1_ff;
         rsp_delayed_count_three <= dly2_ff;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/itp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ITM trace decoder port checker
// Watches the result channel of the decoder for ordering slips.
// ----------------------------------------------------------------------------
module itp_checker #(
   parameter int CHANNEL_COUNT = 10
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [3:0] rsp_channel_index,
   input wire logic       rsp_last_of_entry,
   input wire logic [31:0] rsp_channel_value
);

   // The last flag marks exactly the final channel.
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last_of_entry == (rsp_channel_index == 4'(CHANNEL_COUNT - 1))))
      else $error("last flag does not match the final channel");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_channel_value))
      else $error("stalled result changed");

   // Within an entry, channels follow one another in order.
   a_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_last_of_entry |=>
         rsp_empty || rsp_channel_index == $past(rsp_channel_index) + 4'd1)
      else $error("channel order broken");

   // A new entry starts at channel zero.
   a_first: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && rsp_last_of_entry |=>
         rsp_empty || rsp_channel_index == 4'd0)
      else $error("entry does not start at channel zero");

endmodule

bind itm_trace_packet_decoder_core itp_checker #(
   .CHANNEL_COUNT (CHANNEL_COUNT)
) u_itp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_channel_index (rsp_channel_index),
   .rsp_last_of_entry (rsp_last_of_entry),
   .rsp_channel_value (rsp_channel_value)
);
`default_nettype wire

FILE: verif/tb_itm_trace_packet_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ITM trace packet decoder testbench
// Streams trace bytes into the decoder, predicts every emitted channel row
// with a behavioral decoder model and compares each transfer field by field.
// ----------------------------------------------------------------------------
module tb_itm_trace_packet_decoder_core;
   import itp_pkg::*;

   localparam int NumChannels = ChannelCountDefault;
   localparam int QueueDepth  = PendingDepthDefault;
   localparam int TimeBytes   = MaxTimeBytesDefault;
   localparam logic [27:0] TimeMask = 28'hFFFFFFF;
   localparam int CycleLimit  = 400000;

   typedef struct packed {
      logic [3:0]  ch;
      logic [31:0] value;
      logic [27:0] etime;
      logic        last;
      logic [31:0] frames;
      logic [31:0] errors;
      logic [31:0] d1;
      logic [31:0] d2;
      logic [31:0] d3;
   } row_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_trace_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [3:0]  rsp_channel_index;
   logic [31:0] rsp_channel_value;
   logic [27:0] rsp_entry_time;
   logic        rsp_last_of_entry;
   logic [31:0] rsp_frames_seen;
   logic [31:0] rsp_error_frames;
   logic [31:0] rsp_delayed_count_one;
   logic [31:0] rsp_delayed_count_two;
   logic [31:0] rsp_delayed_count_three;

   itm_trace_packet_decoder_core dut (.*);

   // Clock generation.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Decoder model state.
   phase_type   m_phase;
   logic [1:0]  m_size;
   int          m_count;
   logic [4:0]  m_chan [QueueDepth];
   logic [31:0] m_val [QueueDepth];
   logic [27:0] m_time;
   int          m_tbytes;
   bit          m_tover;
   logic [31:0] m_row [NumChannels];
   logic [31:0] m_frames, m_errors;
   logic [31:0] m_delay [3];

   row_result_type expected_rows[$];
   logic [7:0]     byte_queue[$];
   int             send_idle_pct = 0, recv_idle_pct = 0;
   bit             hold_send = 0;
   int             errors = 0, rows_checked = 0, bytes_sent = 0, cycles = 0;
   logic           took_s = 1'b0;

   task automatic model_reset();
      m_phase = PH_IDLE; m_size = 0; m_count = 0; m_time = 0; m_tbytes = 0;
      m_tover = 0; m_frames = 0; m_errors = 0;
      foreach (m_row[i]) m_row[i] = 0;
      foreach (m_delay[i]) m_delay[i] = 0;
   endtask

   // Fold the queued source values into the row and emit the whole row.
   task automatic close_entry(input logic [27:0] t);
      row_result_type r;
      for (int i = 0; i < m_count; i++) begin
         if (m_chan[i] >= NumChannels) begin
            m_errors++;
            break;
         end
         m_row[m_chan[i]] = m_val[i];
      end
      m_count = 0;
      for (int i = 0; i < NumChannels; i++) begin
         r.ch = i[3:0]; r.value = m_row[i]; r.etime = t & TimeMask;
         r.last = (i == NumChannels - 1); r.frames = m_frames;
         r.errors = m_errors; r.d1 = m_delay[0]; r.d2 = m_delay[1];
         r.d3 = m_delay[2];
         expected_rows = {expected_rows, r};
      end
   endtask

   task automatic add_payload(input logic [7:0] c, input int shift);
      if (m_count < QueueDepth) m_val[m_count] |= 32'(c) << shift;
   endtask

   task automatic finish_payload();
      if (m_count < QueueDepth) m_count++;
      else m_errors++;
      m_phase = PH_IDLE;
   endtask

   task automatic predict_byte(input logic [7:0] c);
      case (m_phase)
         PH_IDLE: begin
            m_frames++;
            if (c[1:0] != 0 && !c[2]) begin
               m_size = c[1:0];
               if (m_count < QueueDepth) begin
                  m_chan[m_count] = c[7:3];
                  m_val[m_count] = 0;
               end
               m_phase = PH_SRC1;
            end else if (c == HdrOverflow) begin
               m_errors++;
            end else if (c[3:0] == 0 && c[6:4] != 0) begin
               if (c == HdrDelayOne) m_delay[0]++;
               else if (c == HdrDelayTwo) m_delay[1]++;
               else if (c == HdrDelayThr) m_delay[2]++;
               m_time = 0; m_tbytes = 0; m_tover = 0;
               if (c[7]) m_phase = PH_TIME;
               else close_entry(28'(c[6:4]));
            end else if ((c & 8'h0B) == 8'h08) begin
               if (c[7]) m_phase = PH_SKIP;
            end else begin
               m_errors++;
            end
         end
         PH_SRC1: begin
            add_payload(c, 0);
            if (m_size == 1) finish_payload(); else m_phase = PH_SRC2;
         end
         PH_SRC2: begin
            add_payload(c, 8);
            if (m_size == 2) finish_payload(); else m_phase = PH_SRC3;
         end
         PH_SRC3: begin
            add_payload(c, 16);
            m_phase = PH_SRC4;
         end
         PH_SRC4: begin
            add_payload(c, 24);
            finish_payload();
         end
         PH_TIME: begin
            if (m_tbytes < TimeBytes) begin
               m_time = (m_time | (28'(c[6:0]) << (7 * m_tbytes))) & TimeMask;
               m_tbytes++;
            end else if (c[6:0] != 0) begin
               m_tover = 1;
            end
            if (!c[7]) begin
               m_phase = PH_IDLE;
               if (m_tover) m_time = TimeMask;
               close_entry(m_time);
            end
         end
         PH_SKIP: if (!c[7]) m_phase = PH_IDLE;
         default: m_phase = PH_IDLE;
      endcase
   endtask

   // Stimulus helpers.
   task automatic add_byte(input logic [7:0] b);
      byte_queue = {byte_queue, b};
   endtask

   task automatic put_source(input int ch, input int sz, input logic [31:0] v);
      add_byte({ch[4:0], 1'b0, sz[1:0]});
      for (int i = 0; i < (sz == 3 ? 4 : sz); i++) add_byte(v[8*i +: 8]);
   endtask

   task automatic put_long_time(input int n);
      add_byte(8'h80 | (8'($urandom_range(1, 7)) << 4));
      for (int i = 0; i < n - 1; i++) add_byte(8'h80 | 8'($urandom));
      add_byte(8'($urandom) & 8'h7F);
   endtask

   task automatic put_random_entry();
      int n;
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++)
         put_source(($urandom_range(0, 19) == 0) ? $urandom_range(10, 31)
                    : $urandom_range(0, 9), $urandom_range(1, 3), $urandom);
      case ($urandom_range(0, 5))
         0: add_byte(8'h70);
         1: add_byte(8'($urandom));
         2: begin
            add_byte(8'h88 | (8'($urandom) & 8'h74));
            add_byte(8'h80 | 8'($urandom));
            add_byte(8'($urandom) & 8'h7F);
         end
         default: ;
      endcase
      if ($urandom_range(0, 1)) put_long_time($urandom_range(1, 6));
      else add_byte({1'b0, 3'($urandom_range(1, 6)), 4'h0});
   endtask

   task automatic wait_drained();
      while (byte_queue.size() != 0 || req_push || expected_rows.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Driver: presents bytes at the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_push || took_s) begin
            if (byte_queue.size() != 0 && !hold_send &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               req_trace_byte <= byte_queue.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: samples both handshakes at the rising edge.
   always @(posedge clock) begin
      row_result_type e;
      took_s <= !reset && req_push && !req_full;
      if (!reset) begin
         cycles++;
         if (req_push && !req_full) begin
            bytes_sent++;
            predict_byte(req_trace_byte);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_rows.size() == 0) begin
               errors++;
               $display("%0t: unexpected row transfer ch=%0d", $time, rsp_channel_index);
            end else begin
               e = expected_rows.pop_front();
               rows_checked++;
               if ({rsp_channel_index, rsp_channel_value, rsp_entry_time,
                    rsp_last_of_entry, rsp_frames_seen, rsp_error_frames,
                    rsp_delayed_count_one, rsp_delayed_count_two,
                    rsp_delayed_count_three} !== e) begin
                  errors++;
                  $display("%0t: expected ch=%0d v=%h t=%h l=%b f=%0d e=%0d d=%0d/%0d/%0d",
                           $time, e.ch, e.value, e.etime, e.last, e.frames, e.errors,
                           e.d1, e.d2, e.d3);
                  $display("%0t: actual   ch=%0d v=%h t=%h l=%b f=%0d e=%0d d=%0d/%0d/%0d",
                           $time, rsp_channel_index, rsp_channel_value, rsp_entry_time,
                           rsp_last_of_entry, rsp_frames_seen, rsp_error_frames,
                           rsp_delayed_count_one, rsp_delayed_count_two,
                           rsp_delayed_count_three);
               end
            end
         end
         if (cycles > CycleLimit) begin
            $display("tb_itm_trace_packet_decoder_core: done, errors");
            $finish;
         end
      end
   end

   initial begin
      model_reset();
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: every packet kind and the special cases.
      add_byte(8'h00);                        // unknown header
      add_byte(8'h70);                        // overflow
      put_source(0, 1, 32'hFF);
      put_source(9, 2, 32'hFFFF);
      put_source(5, 3, 32'hFFFFFFFF);
      add_byte(8'h10);                        // short timestamp
      put_source(31, 1, 32'hA5);              // bad channel stops folding
      put_source(3, 3, 32'h12345678);
      add_byte(8'h08);                        // one-byte extension
      add_byte(8'h8C);                        // extension with payload
      add_byte(8'hFF);
      add_byte(8'h7F);
      add_byte(8'hD0);
      add_byte(8'h7F);
      add_byte(8'hE0);
      add_byte(8'hFF); add_byte(8'hFF);
      add_byte(8'hFF); add_byte(8'hFF);
      add_byte(8'h01);                        // saturating long timestamp
      add_byte(8'hF0);
      add_byte(8'h00);                        // zero timestamp byte adds no time
      add_byte(8'h70);
      wait_drained();

      // Queue overflow: more source packets than the pending depth.
      for (int i = 0; i < QueueDepth + 2; i++) put_source(i % NumChannels, 1, 32'(i));
      add_byte(8'h60);
      while (byte_queue.size() != 0 || req_push) @(posedge clock);
      hold_send = 1;
      wait_drained();
      hold_send = 0;

      // Random phases with changing idle patterns.
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 23 : (p == 1) ? 45 : 0;
         recv_idle_pct = (p == 0) ? 45 : (p == 1) ? 23 : 0;
         for (int k = 0; k < 4; k++) add_byte(8'($urandom));
         put_random_entry();
         wait_drained();
      end

      $display("Decoded %0d trace bytes and checked %0d channel row transfers.",
               bytes_sent, rows_checked);
      if (errors == 0) begin
         $display("tb_itm_trace_packet_decoder_core: done, clean");
      end else begin
         $display("tb_itm_trace_packet_decoder_core: done, errors");
      end
      $finish;
   end
endmodule
